/* hdl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the sorted table range counter: opcodes,
// transaction payload structs and default sizes.
// ----------------------------------------------------------------------------
package stc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned MATCH_BITS = 11;

  // Opcodes carried in the op field.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]            op;
    logic [FIELD_BITS-1:0] load_value;
    logic [FIELD_BITS-1:0] range_low;
    logic [FIELD_BITS-1:0] range_high;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [MATCH_BITS-1:0] match_count;
    logic                  table_full;
  } out_t;

endpackage

/* hdl/stc_table_ram.sv */
// ----------------------------------------------------------------------------
// stc_table_ram
// Table storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stc_table_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered and available in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/stc_lower_bound.sv */
// ----------------------------------------------------------------------------
// stc_lower_bound
// Iterative lower-bound search: finds the first filled entry that is not
// below the bound, each step a table probe in S_PROBE and a compare in S_CMP.
// ----------------------------------------------------------------------------
module stc_lower_bound #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_BITS  = 32,
  localparam int unsigned ADDR_BITS  = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_BITS   = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] bound,
  input  logic [CNT_BITS-1:0]   count,
  output logic                  rd_en,
  output logic [ADDR_BITS-1:0]  rd_addr,
  input  logic [VALUE_BITS-1:0] rd_data,
  output logic                  done,
  output logic [CNT_BITS-1:0]   index
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP
  } state_t;

  state_t              state;
  logic [CNT_BITS-1:0] lo;
  logic [CNT_BITS-1:0] hi;
  logic [CNT_BITS-1:0] mid;
  logic [CNT_BITS-1:0] mid_next;

  // Midpoint of the half-open interval, written so that it cannot overflow.
  assign mid_next = lo + ((hi - lo) >> 1);

  // A probe is issued while the interval is still non-empty.
  assign rd_en   = (state == S_PROBE) && (lo < hi);
  assign rd_addr = mid_next[ADDR_BITS-1:0];
  assign index   = lo;

  // Search sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      lo    <= '0;
      hi    <= '0;
      mid   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lo    <= '0;
            hi    <= count;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= S_CMP;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CMP: begin
          // The shared compare narrows the interval by one half.
          if (rd_data < bound) begin
            lo <= mid + CNT_BITS'(1);
          end else begin
            hi <= mid;
          end
          state <= S_PROBE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A probe is always followed by its compare.
  a_probe_then_cmp: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == S_CMP))
    else $error("probe not followed by compare");

  // Probes only touch filled entries.
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (mid_next < count))
    else $error("probe beyond filled part of table");

  // The interval never inverts while a search runs.
  a_interval_order: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (lo <= hi))
    else $error("search interval inverted");

endmodule

/* hdl/sorted_table_range_count.sv */
// ----------------------------------------------------------------------------
// sorted_table_range_count
// Sorted table with range counting by two lower-bound binary searches.
// ----------------------------------------------------------------------------
// Usage
//   Input transactions on in_valid/in_ready carry an opcode and three values.
//   A clear empties the table and gives no result. An append stores one value
//   at the end of the table and gives one result whose table_full bit is set
//   when the table already held TABLE_DEPTH entries. A query gives one result
//   with the number of entries in [range_low, range_high). Opcode 3 is dropped.
//   Results leave on out_valid/out_ready from an output register.
// Handshake and sequencing
//   in_ready is high only while the sequencer is idle; one transaction is
//   worked on at a time. Append results, and results of empty ranges, go
//   from the T_RESULT state into the output register. A query runs two
//   searches on one shared compare unit; each table probe waits for the
//   table RAM's registered read before its compare.
// Reset and stalls
//   Reset empties the table and clears out_valid. While the receiver
//   stalls the result is held, and the block may accept one more append or
//   query but completes it only once the output register frees up.
// ----------------------------------------------------------------------------
module sorted_table_range_count #(
  parameter int unsigned TABLE_DEPTH = stc_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = stc_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  stc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output stc_pkg::out_t out_data
);

  import stc_pkg::*;

  localparam int unsigned ADDR_BITS = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EXT_BITS  = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int unsigned DIFF_EXT  = (CNT_BITS > MATCH_BITS) ? CNT_BITS : MATCH_BITS;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SRCH_HI,
    T_SRCH_LO,
    T_RESULT
  } state_t;

  state_t                state;
  logic [CNT_BITS-1:0]   entry_count;
  logic [VALUE_BITS-1:0] bound_lo;
  logic [VALUE_BITS-1:0] bound_hi;
  logic [CNT_BITS-1:0]   idx_hi;
  logic                  srch_start;
  out_t                  res;

  logic                  accept;
  logic [EXT_BITS-1:0]   load_ext;
  logic [EXT_BITS-1:0]   low_ext;
  logic [EXT_BITS-1:0]   high_ext;
  logic [VALUE_BITS-1:0] load_val;
  logic [VALUE_BITS-1:0] low_val;
  logic [VALUE_BITS-1:0] high_val;
  logic                  wr_en;
  logic                  has_room;

  logic                  rd_en;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  srch_done;
  logic [CNT_BITS-1:0]   srch_index;
  logic [VALUE_BITS-1:0] srch_bound;
  logic [CNT_BITS-1:0]   diff;
  logic [DIFF_EXT-1:0]   diff_ext;

  assign in_ready = (state == T_IDLE);
  assign accept   = in_valid && in_ready;

  // Input values fitted to the stored value width (zero-extended or truncated).
  assign load_ext = EXT_BITS'(in_data.load_value);
  assign low_ext  = EXT_BITS'(in_data.range_low);
  assign high_ext = EXT_BITS'(in_data.range_high);
  assign load_val = load_ext[VALUE_BITS-1:0];
  assign low_val  = low_ext[VALUE_BITS-1:0];
  assign high_val = high_ext[VALUE_BITS-1:0];

  // Appends are written straight into the table when there is room.
  assign has_room = (entry_count < CNT_BITS'(TABLE_DEPTH));
  assign wr_en    = accept && (in_data.op == OP_APPEND) && has_room;

  // The first search uses the upper bound, the second the lower one.
  assign srch_bound = (state == T_SRCH_LO) ? bound_lo : bound_hi;

  // Count of entries between the two search results, floored at zero.
  assign diff     = (idx_hi > srch_index) ? (idx_hi - srch_index) : '0;
  assign diff_ext = DIFF_EXT'(diff);

  stc_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[ADDR_BITS-1:0]),
    .wr_data (load_val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stc_lower_bound #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (srch_start),
    .bound   (srch_bound),
    .count   (entry_count),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (srch_done),
    .index   (srch_index)
  );

  // Transaction sequencer, table fill count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      entry_count <= '0;
      srch_start  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      srch_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            unique case (in_data.op)
              OP_CLEAR: begin
                entry_count <= '0;
              end
              OP_APPEND: begin
                if (has_room) begin
                  entry_count <= entry_count + CNT_BITS'(1);
                end
                res.match_count <= '0;
                res.table_full  <= !has_room;
                state           <= T_RESULT;
              end
              OP_QUERY: begin
                bound_lo        <= low_val;
                bound_hi        <= high_val;
                res.match_count <= '0;
                res.table_full  <= 1'b0;
                if (high_val > low_val) begin
                  srch_start <= 1'b1;
                  state      <= T_SRCH_HI;
                end else begin
                  state <= T_RESULT;
                end
              end
              default: begin
                state <= T_IDLE;
              end
            endcase
          end
        end
        T_SRCH_HI: begin
          if (srch_done) begin
            idx_hi     <= srch_index;
            srch_start <= 1'b1;
            state      <= T_SRCH_LO;
          end
        end
        T_SRCH_LO: begin
          if (srch_done) begin
            res.match_count <= diff_ext[MATCH_BITS-1:0];
            state           <= T_RESULT;
          end
        end
        T_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // The fill count never exceeds the table depth.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_BITS'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A clear transaction empties the table.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.op == OP_CLEAR)) |=> (entry_count == '0))
    else $error("clear did not empty the table");

  // Search completions arrive only while a search is expected.
  a_done_in_search: assert property (@(posedge clk) disable iff (rst)
    srch_done |-> ((state == T_SRCH_HI) || (state == T_SRCH_LO)))
    else $error("search completion outside a query");

  // The table is never written while a search reads it.
  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == T_IDLE))
    else $error("table written during a query");

endmodule
